// ----- design/clcd_pkg.sv -----
// Shared types, codes and constant tables for the character-LCD write sequencer.
// Holds the microcode table, the glyph tables and the control word layout.
// No dependencies.
package clcd_pkg;

	// request codes carried in s_tuser
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_DATA   = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_BIG    = 3'd4;
	localparam logic [2:0] OP_SEG    = 3'd5;

	localparam int PC_W     = 5;
	localparam int PROG_LEN = 30;

	// program entry points
	localparam logic [PC_W-1:0] PC_INIT   = 5'd0;
	localparam logic [PC_W-1:0] PC_CMD    = 5'd12;
	localparam logic [PC_W-1:0] PC_DATA   = 5'd14;
	localparam logic [PC_W-1:0] PC_CURSOR = 5'd16;
	localparam logic [PC_W-1:0] PC_BIG    = 5'd18;
	localparam logic [PC_W-1:0] PC_SEG    = 5'd26;

	// wait codes in ms
	localparam logic [4:0] WB_NONE = 5'd0;
	localparam logic [4:0] WB_BOOT = 5'd20;
	localparam logic [3:0] WA_STD  = 4'd1;
	localparam logic [3:0] WA_CUR  = 4'd2;
	localparam logic [3:0] WA_LONG = 4'd11;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] CGRAM_BASE = 8'h40;

	// byte source selector of the datapath
	typedef enum logic [2:0] {
		SRC_CONST,
		SRC_BYTE,
		SRC_CUR0,
		SRC_CUR1,
		SRC_DIGIT,
		SRC_SEGCMD,
		SRC_SEGROW
	} src_t;

	typedef struct packed {
		src_t             src;
		logic [7:0]       konst;
		logic             hi;
		logic             rs;
		logic [4:0]       wait_pre;
		logic [3:0]       after;
		logic             inc;
		logic             loop;
		logic [2:0]       limit;
		logic [PC_W-1:0]  target;
		logic             last;
	} ctrl_word_t;

	// start request from the top level to the sequencer
	typedef struct packed {
		logic            start;
		logic [PC_W-1:0] entry;
	} seq_cmd_t;

	// sequencer status back to the top level
	typedef struct packed {
		logic busy;
		logic last;
	} seq_stat_t;

	localparam logic [7:0] LINE_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

	localparam logic [7:0] DIGIT_MAP [13][6] = '{
		'{8'd0,  8'd1,  8'd2,  8'd5,  8'd3,  8'd4},
		'{8'd1,  8'd2,  8'd32, 8'd3,  8'd7,  8'd3},
		'{8'd6,  8'd6,  8'd2,  8'd5,  8'd3,  8'd3},
		'{8'd6,  8'd6,  8'd2,  8'd3,  8'd3,  8'd4},
		'{8'd7,  8'd3,  8'd7,  8'd32, 8'd32, 8'd7},
		'{8'd7,  8'd6,  8'd6,  8'd3,  8'd3,  8'd4},
		'{8'd0,  8'd6,  8'd6,  8'd5,  8'd3,  8'd4},
		'{8'd1,  8'd1,  8'd7,  8'd32, 8'd32, 8'd7},
		'{8'd0,  8'd6,  8'd2,  8'd5,  8'd3,  8'd4},
		'{8'd0,  8'd6,  8'd2,  8'd3,  8'd3,  8'd4},
		'{8'd32, 8'd32, 8'd32, 8'd32, 8'd32, 8'd32},
		'{8'd0,  8'd1,  8'd32, 8'd5,  8'd3,  8'd32},
		'{8'd32, 8'd32, 8'd32, 8'd0,  8'd1,  8'd2}
	};

	localparam logic [7:0] SEG_ROWS [8][8] = '{
		'{8'h07, 8'h0F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1C, 8'h1E, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1E, 8'h1C},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h0F, 8'h07},
		'{8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F}
	};

	// big digit character; out-of-range glyphs and slots draw blanks
	function automatic logic [7:0] digit_char(input logic [3:0] glyph, input logic [2:0] k);
		logic [7:0] ch;
		ch = BLANK_CHAR;
		if (glyph < 4'd13 && k < 3'd6) begin
			ch = DIGIT_MAP[glyph][k];
		end
		return ch;
	endfunction

	function automatic ctrl_word_t cw_mk(
		input src_t            src,
		input logic [7:0]      konst,
		input logic            hi,
		input logic            rs,
		input logic [4:0]      wait_pre,
		input logic [3:0]      after,
		input logic            inc,
		input logic            loop,
		input logic [2:0]      limit,
		input logic [PC_W-1:0] target,
		input logic            last
	);
		ctrl_word_t w;
		w.src      = src;
		w.konst    = konst;
		w.hi       = hi;
		w.rs       = rs;
		w.wait_pre = wait_pre;
		w.after    = after;
		w.inc      = inc;
		w.loop     = loop;
		w.limit    = limit;
		w.target   = target;
		w.last     = last;
		return w;
	endfunction

	// microprogram: one control word per nibble write
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			// power-up init
			5'd0:  w = cw_mk(SRC_CONST, 8'h03, 1'b0, 1'b0, WB_BOOT, WA_LONG, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd1:  w = cw_mk(SRC_CONST, 8'h03, 1'b0, 1'b0, WB_NONE, WA_LONG, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd2:  w = cw_mk(SRC_CONST, 8'h03, 1'b0, 1'b0, WB_NONE, WA_LONG, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd3:  w = cw_mk(SRC_CONST, 8'h02, 1'b0, 1'b0, WB_NONE, WA_LONG, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd4:  w = cw_mk(SRC_CONST, 8'h28, 1'b1, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd5:  w = cw_mk(SRC_CONST, 8'h28, 1'b0, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd6:  w = cw_mk(SRC_CONST, 8'h0C, 1'b1, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd7:  w = cw_mk(SRC_CONST, 8'h0C, 1'b0, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd8:  w = cw_mk(SRC_CONST, 8'h06, 1'b1, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd9:  w = cw_mk(SRC_CONST, 8'h06, 1'b0, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd10: w = cw_mk(SRC_CONST, 8'h01, 1'b1, 1'b0, WB_NONE, WA_STD,  1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd11: w = cw_mk(SRC_CONST, 8'h01, 1'b0, 1'b0, WB_NONE, WA_LONG, 1'b0, 1'b0, 3'd0, 5'd0, 1'b1);
			// raw command
			5'd12: w = cw_mk(SRC_BYTE, 8'h00, 1'b1, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd13: w = cw_mk(SRC_BYTE, 8'h00, 1'b0, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b1);
			// data byte
			5'd14: w = cw_mk(SRC_BYTE, 8'h00, 1'b1, 1'b1, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd15: w = cw_mk(SRC_BYTE, 8'h00, 1'b0, 1'b1, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b1);
			// cursor set
			5'd16: w = cw_mk(SRC_CUR0, 8'h00, 1'b1, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b0);
			5'd17: w = cw_mk(SRC_CUR0, 8'h00, 1'b0, 1'b0, WB_NONE, WA_CUR, 1'b0, 1'b0, 3'd0, 5'd0, 1'b1);
			// big digit: top line, three characters, then next line
			5'd18: w = cw_mk(SRC_CUR0,  8'h00, 1'b1, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd19: w = cw_mk(SRC_CUR0,  8'h00, 1'b0, 1'b0, WB_NONE, WA_CUR, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd20: w = cw_mk(SRC_DIGIT, 8'h00, 1'b1, 1'b1, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd21: w = cw_mk(SRC_DIGIT, 8'h00, 1'b0, 1'b1, WB_NONE, WA_STD, 1'b1, 1'b1, 3'd2, 5'd20, 1'b0);
			5'd22: w = cw_mk(SRC_CUR1,  8'h00, 1'b1, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd23: w = cw_mk(SRC_CUR1,  8'h00, 1'b0, 1'b0, WB_NONE, WA_CUR, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd24: w = cw_mk(SRC_DIGIT, 8'h00, 1'b1, 1'b1, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd25: w = cw_mk(SRC_DIGIT, 8'h00, 1'b0, 1'b1, WB_NONE, WA_STD, 1'b1, 1'b1, 3'd5, 5'd24, 1'b1);
			// segment glyph upload: CGRAM address, then eight rows
			5'd26: w = cw_mk(SRC_SEGCMD, 8'h00, 1'b1, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd27: w = cw_mk(SRC_SEGCMD, 8'h00, 1'b0, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd28: w = cw_mk(SRC_SEGROW, 8'h00, 1'b1, 1'b1, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0,  1'b0);
			5'd29: w = cw_mk(SRC_SEGROW, 8'h00, 1'b0, 1'b1, WB_NONE, WA_STD, 1'b1, 1'b1, 3'd7, 5'd28, 1'b1);
			default: w = cw_mk(SRC_CONST, 8'h00, 1'b0, 1'b0, WB_NONE, WA_STD, 1'b0, 1'b0, 3'd0, 5'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

// ----- design/clcd_useq.sv -----
// Microcode sequencer: step counter, loop index and the control word ROM.
// Depends on clcd_pkg.
module clcd_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clcd_pkg::seq_cmd_t   cmd,
	input  logic                 adv,
	output clcd_pkg::ctrl_word_t cw,
	output logic [2:0]           idx,
	output clcd_pkg::seq_stat_t  stat
);
	import clcd_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [2:0]      idx_q;
	logic            busy_q;
	logic            taken;
	logic            step;

	// control word of the current step
	assign cw    = ucode(pc_q);
	assign idx   = idx_q;
	assign taken = cw.loop && (idx_q != cw.limit);
	assign step  = busy_q && adv;

	assign stat.busy = busy_q;
	assign stat.last = cw.last && !taken;

	// step counter, loop index, run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			pc_q   <= cmd.entry;
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (step) begin
			pc_q <= taken ? cw.target : pc_q + 1'b1;
			if (cw.inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (stat.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q < PC_W'(PROG_LEN))
		else $error("step counter left the program");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && stat.last && !cmd.start) |=> !busy_q)
		else $error("run continued past its final write");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("new run started while one is in progress");

	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cw.loop) |-> idx_q <= cw.limit)
		else $error("loop index ran past its limit");

endmodule

// ----- design/char_lcd_4bit_write_sequencer_unit.sv -----
// Top level of the character-LCD 4-bit write sequencer.
// Request registers, byte datapath and output register; depends on clcd_pkg, clcd_useq.
// The first write beat of a request passes the sequencer start and the output register.
// Throughput: one write per cycle while m_tready is high; a request emits one nibble per
// step of the microcode sequencer, and a new request is accepted only once the
// sequencer is idle; requests that emit nothing leave it idle.
// Reset: arst_n clears the run and the output valid; s_tready is high after reset.
module char_lcd_4bit_write_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_value[7:0], row[9:8], column[14:10], digit_glyph[18:15],
	// segment[21:19], zero[23:22]
	input  logic [23:0] s_tdata,
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // nibble[3:0], wait_before_ms[8:4], wait_after_ms[12:9], zero[15:13]
	output logic        m_tuser,  // reg_select
	output logic        m_tlast
);
	import clcd_pkg::*;

	logic [7:0] byte_q;
	logic [1:0] row_q;
	logic [4:0] col_q;
	logic [3:0] glyph_q;
	logic [2:0] seg_q;

	logic       m_valid_q;
	logic [3:0] nib_q;
	logic       rs_q;
	logic [4:0] wait_pre_q;
	logic [3:0] after_q;
	logic       last_q;

	logic       s_fire;
	logic       out_free;
	logic       run_en;
	logic [PC_W-1:0] entry;
	logic [7:0] sel_byte;
	logic [1:0] row_next;

	seq_cmd_t   cmd;
	seq_stat_t  stat;
	ctrl_word_t cw;
	logic [2:0] idx;

	assign s_tready = !stat.busy;
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// entry point per opcode; empty runs start nothing
	always_comb begin
		entry  = PC_INIT;
		run_en = 1'b1;
		case (s_tuser)
			OP_INIT:   entry = PC_INIT;
			OP_CMD:    entry = PC_CMD;
			OP_DATA:   entry = PC_DATA;
			OP_CURSOR: entry = PC_CURSOR;
			OP_BIG: begin
				entry  = PC_BIG;
				run_en = (s_tdata[9:8] != 2'd3);
			end
			OP_SEG:    entry = PC_SEG;
			default:   run_en = 1'b0;
		endcase
	end

	assign cmd.start = s_fire && run_en;
	assign cmd.entry = entry;

	// request fields
	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_q  <= s_tdata[7:0];
			row_q   <= s_tdata[9:8];
			col_q   <= s_tdata[14:10];
			glyph_q <= s_tdata[18:15];
			seg_q   <= s_tdata[21:19];
		end
	end

	clcd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.adv    (out_free),
		.cw     (cw),
		.idx    (idx),
		.stat   (stat)
	);

	// byte source selection
	assign row_next = row_q + 2'd1;
	always_comb begin
		case (cw.src)
			SRC_CONST:  sel_byte = cw.konst;
			SRC_BYTE:   sel_byte = byte_q;
			SRC_CUR0:   sel_byte = LINE_BASE[row_q] + {3'b000, col_q};
			SRC_CUR1:   sel_byte = LINE_BASE[row_next] + {3'b000, col_q};
			SRC_DIGIT:  sel_byte = digit_char(glyph_q, idx);
			SRC_SEGCMD: sel_byte = CGRAM_BASE + {2'b00, seg_q, 3'b000};
			SRC_SEGROW: sel_byte = SEG_ROWS[seg_q][idx];
			default:    sel_byte = BLANK_CHAR;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= stat.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && stat.busy) begin
			nib_q      <= cw.hi ? sel_byte[7:4] : sel_byte[3:0];
			rs_q       <= cw.rs;
			wait_pre_q <= cw.wait_pre;
			after_q    <= cw.after;
			last_q     <= stat.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, after_q, wait_pre_q, nib_q};
	assign m_tuser  = rs_q;
	assign m_tlast  = last_q;

	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && !run_en) |=> s_tready)
		else $error("request without writes stalled the input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
			(m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
		else $error("stalled write beat changed");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !s_tready)
		else $error("request accepted during a run");

endmodule

// ----- tb/sv/tb_char_lcd_4bit_write_sequencer_unit.sv -----
// Testbench for the character-LCD 4-bit write sequencer: predicts every nibble write
// of each request beat and checks the output stream against it; depends on clcd_pkg.
// Directed requests first, then random ones, with random stalls on both sides.
package lcd_write_model_pkg;
	import clcd_pkg::*;

	// one expected bus write
	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic [4:0] wait_pre;
		logic [3:0] after;
		logic       last;
	} lcd_write_t;

	// init sequence codes
	localparam logic [3:0] WAKE_NIBBLE       = 4'h3;
	localparam logic [3:0] BUS_4BIT_NIBBLE   = 4'h2;
	localparam logic [7:0] FUNC_4BIT_2LINE   = 8'h28;
	localparam logic [7:0] DISPLAY_ON        = 8'h0C;
	localparam logic [7:0] ENTRY_INCREMENT   = 8'h06;
	localparam logic [7:0] CLEAR_DISPLAY     = 8'h01;

	localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

	// big digit: three characters on the top line, three below
	localparam logic [7:0] BIG_GLYPHS [13][6] = '{
		'{8'd0,  8'd1,  8'd2,  8'd5,  8'd3,  8'd4},
		'{8'd1,  8'd2,  8'd32, 8'd3,  8'd7,  8'd3},
		'{8'd6,  8'd6,  8'd2,  8'd5,  8'd3,  8'd3},
		'{8'd6,  8'd6,  8'd2,  8'd3,  8'd3,  8'd4},
		'{8'd7,  8'd3,  8'd7,  8'd32, 8'd32, 8'd7},
		'{8'd7,  8'd6,  8'd6,  8'd3,  8'd3,  8'd4},
		'{8'd0,  8'd6,  8'd6,  8'd5,  8'd3,  8'd4},
		'{8'd1,  8'd1,  8'd7,  8'd32, 8'd32, 8'd7},
		'{8'd0,  8'd6,  8'd2,  8'd5,  8'd3,  8'd4},
		'{8'd0,  8'd6,  8'd2,  8'd3,  8'd3,  8'd4},
		'{8'd32, 8'd32, 8'd32, 8'd32, 8'd32, 8'd32},
		'{8'd0,  8'd1,  8'd32, 8'd5,  8'd3,  8'd32},
		'{8'd32, 8'd32, 8'd32, 8'd0,  8'd1,  8'd2}
	};

	// CGRAM row patterns of the eight segment glyphs
	localparam logic [7:0] CGRAM_PATTERNS [8][8] = '{
		'{8'h07, 8'h0F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1C, 8'h1E, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1E, 8'h1C},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h0F, 8'h07},
		'{8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h1F},
		'{8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F}
	};

	class lcd_write_board;
		lcd_write_t pending[$];
		lcd_write_t run[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// print is capped so a broken block cannot flood the log
		task report(string msg);
			if (errors < 100) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
			errors++;
		endtask

		function void add_write(logic [3:0] nib, logic rs, logic [4:0] wait_pre,
				logic [3:0] after);
			lcd_write_t w;
			w.nibble   = nib;
			w.rs       = rs;
			w.wait_pre = wait_pre;
			w.after    = after;
			w.last     = 1'b0;
			run.push_back(w);
		endfunction

		// high nibble first, hold after the low one as given
		function void add_byte(logic [7:0] b, logic rs, logic [3:0] after_low);
			add_write(b[7:4], rs, WB_NONE, WA_STD);
			add_write(b[3:0], rs, WB_NONE, after_low);
		endfunction

		function void add_cursor(logic [1:0] row, logic [4:0] col);
			logic [7:0] addr;
			addr = ROW_ADDR[row] + {3'b000, col};
			add_byte(addr, 1'b0, WA_CUR);
		endfunction

		// expand one accepted request beat into its run of writes
		function void note_request(logic [2:0] op, logic [7:0] bv, logic [1:0] row,
				logic [4:0] col, logic [3:0] glyph, logic [2:0] seg);
			lcd_write_t w;
			logic [7:0] ch;
			run.delete();
			case (op)
				OP_INIT: begin
					add_write(WAKE_NIBBLE, 1'b0, WB_BOOT, WA_LONG);
					add_write(WAKE_NIBBLE, 1'b0, WB_NONE, WA_LONG);
					add_write(WAKE_NIBBLE, 1'b0, WB_NONE, WA_LONG);
					add_write(BUS_4BIT_NIBBLE, 1'b0, WB_NONE, WA_LONG);
					add_byte(FUNC_4BIT_2LINE, 1'b0, WA_STD);
					add_byte(DISPLAY_ON, 1'b0, WA_STD);
					add_byte(ENTRY_INCREMENT, 1'b0, WA_STD);
					add_byte(CLEAR_DISPLAY, 1'b0, WA_LONG);
				end
				OP_CMD:    add_byte(bv, 1'b0, WA_STD);
				OP_DATA:   add_byte(bv, 1'b1, WA_STD);
				OP_CURSOR: add_cursor(row, col);
				OP_BIG: begin
					// bottom line has no line below: nothing is drawn
					if (row != 2'd3) begin
						for (int k = 0; k < 6; k++) begin
							ch = (glyph < 4'd13) ? BIG_GLYPHS[glyph][k] : BLANK_CHAR;
							if (k == 0) begin
								add_cursor(row, col);
							end else if (k == 3) begin
								add_cursor(row + 2'd1, col);
							end
							add_byte(ch, 1'b1, WA_STD);
						end
					end
				end
				OP_SEG: begin
					add_byte(CGRAM_BASE + {2'b00, seg, 3'b000}, 1'b0, WA_STD);
					for (int k = 0; k < 8; k++) begin
						add_byte(CGRAM_PATTERNS[seg][k], 1'b1, WA_STD);
					end
				end
				default: ;
			endcase
			if (run.size() > 0) begin
				w = run.pop_back();
				w.last = 1'b1;
				run.push_back(w);
			end
			foreach (run[i]) begin
				pending.push_back(run[i]);
			end
		endfunction

		// compare one output beat with the oldest expected write
		task check_write(lcd_write_t got);
			lcd_write_t exp_w;
			if (pending.size() == 0) begin
				report($sformatf("write with nothing pending: nibble %h rs %b last %b",
					got.nibble, got.rs, got.last));
				return;
			end
			exp_w = pending.pop_front();
			if (got.nibble !== exp_w.nibble)
				report($sformatf("nibble %h, want %h", got.nibble, exp_w.nibble));
			if (got.rs !== exp_w.rs)
				report($sformatf("reg_select %b, want %b", got.rs, exp_w.rs));
			if (got.wait_pre !== exp_w.wait_pre)
				report($sformatf("wait_before %0d, want %0d", got.wait_pre, exp_w.wait_pre));
			if (got.after !== exp_w.after)
				report($sformatf("wait_after %0d, want %0d", got.after, exp_w.after));
			if (got.last !== exp_w.last)
				report($sformatf("last %b, want %b", got.last, exp_w.last));
		endtask
	endclass
endpackage

module tb_char_lcd_4bit_write_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import clcd_pkg::*;
	import lcd_write_model_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_REQUESTS = 200;
	localparam int LONG_HOLD       = 400;
	localparam int TAIL_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // byte_value, row, column, digit_glyph, segment, zero pad
	logic [2:0]  s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // nibble, wait_before_ms, wait_after_ms, zero pad
	logic        m_tuser;  // reg_select
	logic        m_tlast;

	lcd_write_board board;
	int             writes_seen;
	int             idle_cycles;

	char_lcd_4bit_write_sequencer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 92) return $urandom_range(1, 3);
		else return $urandom_range(8, 40);
	endfunction

	// offer one request beat and wait for it to be taken
	task automatic send_request(logic [2:0] op, logic [7:0] bv, logic [1:0] row,
			logic [4:0] col, logic [3:0] glyph, logic [2:0] seg, bit quiet);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, seg, glyph, col, row, bv};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(op, bv, row, col, glyph, seg);
	endtask

	// random request, weighted toward the long runs
	task automatic send_random(bit quiet);
		int         r;
		logic [2:0] op;
		logic [4:0] col;
		logic [3:0] glyph;
		r = $urandom_range(0, 99);
		if (r < 6) op = OP_INIT;
		else if (r < 20) op = OP_CMD;
		else if (r < 34) op = OP_DATA;
		else if (r < 50) op = OP_CURSOR;
		else if (r < 72) op = OP_BIG;
		else if (r < 94) op = OP_SEG;
		else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		col   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
		glyph = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
		send_request(op, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), col, glyph,
			3'($urandom_range(0, 7)), quiet);
	endtask

	// output side: random stalls, one long hold-off to back up the input
	initial begin
		int         stall_left;
		bit         hold_done;
		lcd_write_t w;
		stall_left = 0;
		hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				w.nibble   = m_tdata[3:0];
				w.wait_pre = m_tdata[8:4];
				w.after    = m_tdata[12:9];
				w.rs       = m_tuser;
				w.last     = m_tlast;
				board.check_write(w);
				writes_seen++;
			end
			if (!hold_done && writes_seen >= 60) begin
				hold_done  = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ((writes_seen % 300) < 220 && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		board       = new();
		writes_seen = 0;
		idle_cycles = 0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= OP_INIT;
		m_tready    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every request kind and the corner cases
		send_request(OP_INIT,   8'h00, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_CMD,    8'h00, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_CMD,    8'hFF, 2'd3, 5'd31, 4'd15, 3'd7, 1'b0);
		send_request(OP_DATA,   8'hA5, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_DATA,   8'h5A, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_CURSOR, 8'h00, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_CURSOR, 8'h00, 2'd1, 5'd19, 4'd0,  3'd0, 1'b0);
		send_request(OP_CURSOR, 8'h00, 2'd2, 5'd10, 4'd0,  3'd0, 1'b0);
		send_request(OP_CURSOR, 8'h00, 2'd3, 5'd31, 4'd0,  3'd0, 1'b0);
		send_request(OP_BIG,    8'h00, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_BIG,    8'h00, 2'd1, 5'd7,  4'd9,  3'd0, 1'b0);
		send_request(OP_BIG,    8'h00, 2'd2, 5'd31, 4'd12, 3'd0, 1'b0);
		// bottom line start draws nothing
		send_request(OP_BIG,    8'h00, 2'd3, 5'd4,  4'd5,  3'd0, 1'b0);
		// glyph index past the table draws blanks
		send_request(OP_BIG,    8'h00, 2'd0, 5'd16, 4'd15, 3'd0, 1'b0);
		send_request(OP_BIG,    8'h00, 2'd1, 5'd2,  4'd13, 3'd0, 1'b0);
		send_request(OP_SEG,    8'h00, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);
		send_request(OP_SEG,    8'h00, 2'd0, 5'd0,  4'd0,  3'd7, 1'b0);
		send_request(OP_SEG,    8'h00, 2'd0, 5'd0,  4'd0,  3'd3, 1'b0);
		// spare opcodes emit nothing
		send_request(OP_SPARE_LO, 8'hFF, 2'd1, 5'd1, 4'd1, 3'd1, 1'b0);
		send_request(OP_SPARE_HI, 8'h00, 2'd2, 5'd2, 4'd2, 3'd2, 1'b0);
		send_request(OP_CMD,    8'h80, 2'd0, 5'd0,  4'd0,  3'd0, 1'b0);

		// random part, with back-to-back stretches
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			send_random((i % 50) >= 40);
		end
		s_tvalid <= 1'b0;

		// drain, then give stray writes a chance to show up
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending.size() != 0)
			board.report($sformatf("%0d writes never arrived", board.pending.size()));

		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
